/* design/tle_pkg.sv */
// shared types and constants for the terminal line editor
`default_nettype none

package tle_pkg;

  localparam int BUF_DEPTH   = 32;
  localparam int STORE_DEPTH = 32;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int EFF_MAX     = (BUF_DEPTH < STORE_DEPTH) ? BUF_DEPTH : STORE_DEPTH;

  localparam logic [5:0] CAP_RESET = 6'd32;
  localparam logic [5:0] CAP_MIN   = 6'd2;
  localparam logic [5:0] CAP_MAX   = 6'(EFF_MAX);

  // input commands
  localparam logic [1:0] CMD_RX      = 2'd0;
  localparam logic [1:0] CMD_FAIL    = 2'd1;
  localparam logic [1:0] CMD_PRELOAD = 2'd2;

  // line status codes
  localparam logic [2:0] ST_EDIT   = 3'd0;
  localparam logic [2:0] ST_DONE   = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_FAILED = 3'd3;
  localparam logic [2:0] ST_CLOSED = 3'd4;

  // escape parse phase
  localparam logic [1:0] ESC_NORMAL = 2'd0;
  localparam logic [1:0] ESC_AFTER  = 2'd1;
  localparam logic [1:0] ESC_CSI    = 2'd2;

  // control characters
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_EOT    = 8'h04;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_KILL   = 8'h15;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] FINAL_LO  = 8'h40;
  localparam logic [7:0] FINAL_HI  = 8'h7E;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic [4:0] erase_count;
    logic [2:0] status;
    logic [4:0] line_length;
    logic       line_valid;
    logic [7:0] line_byte;
    logic       last;
  } out_t;

  typedef struct packed {
    logic capture_in;
    logic eval_load;
    logic rd_issue;
    logic rd_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic line_more;
    logic rd_last;
  } stat_t;

endpackage

`default_nettype wire

/* design/tle_ctrl.sv */
// controller state machine for the terminal line editor
`default_nettype none

module tle_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire tle_pkg::stat_t stat_i,
  output tle_pkg::cmd_t      cmd_o
);
  import tle_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_LD   = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture_in = 1'b1;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat_i.out_free) begin
          cmd_o.eval_load = 1'b1;
          state_d = stat_i.line_more ? S_RD : S_IDLE;
        end
      end
      S_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d = S_LD;
      end
      S_LD: begin
        if (stat_i.out_free) begin
          cmd_o.rd_load = 1'b1;
          state_d = stat_i.rd_last ? S_IDLE : S_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* design/tle_dpath.sv */
// datapath: line store, fill count, escape phase and result register
`default_nettype none

module tle_dpath (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tle_pkg::in_t  in_data_i,
  input  wire logic          cfg_we_i,
  input  wire logic [5:0]    cfg_data_i,
  input  wire tle_pkg::cmd_t cmd_i,
  output tle_pkg::stat_t     stat_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output tle_pkg::out_t      out_data_o
);
  import tle_pkg::*;

  logic [7:0]          mem_q [STORE_DEPTH];
  logic [7:0]          rdata_q;
  in_t                 in_q;
  logic [5:0]          cap_q;
  logic [STORE_AW-1:0] fill_q, fill_d;
  logic [1:0]          esc_q, esc_d;
  logic [4:0]          end_len_q;
  logic [2:0]          end_st_q;
  logic [STORE_AW-1:0] rd_idx_q;
  out_t                out_q, res;
  out_t                rd_res;
  logic                out_valid_q;

  logic [5:0]          cap_clamp;
  logic [4:0]          limit;
  logic [STORE_AW-1:0] fill_inc;
  logic                wr_en;
  logic                ends;
  logic [7:0]          b;

  always_comb begin
    cap_clamp = cap_q;
    if (cap_q < CAP_MIN) cap_clamp = CAP_MIN;
    if (cap_q > CAP_MAX) cap_clamp = CAP_MAX;
    limit = 5'(cap_clamp - 6'd1);
  end

  assign b        = in_q.data_byte;
  assign fill_inc = fill_q + 1'b1;

  always_comb begin
    fill_d = fill_q;
    esc_d  = esc_q;
    wr_en  = 1'b0;
    ends   = 1'b0;
    res    = '0;
    res.status      = ST_EDIT;
    res.line_length = 5'(fill_q);
    res.last        = 1'b1;
    priority if (in_q.cmd == CMD_FAIL) begin
      ends = 1'b1;
      res.status = ST_FAILED;
    end else if (in_q.cmd != CMD_RX && in_q.cmd != CMD_PRELOAD) begin
      // unused command, plain editing result
    end else if (5'(fill_q) >= limit) begin
      ends = 1'b1;
      res.status = ST_FULL;
    end else if (in_q.cmd == CMD_PRELOAD) begin
      wr_en = 1'b1;
      fill_d = fill_inc;
      res.line_length = 5'(fill_inc);
      if (5'(fill_inc) >= limit) begin
        ends = 1'b1;
        res.status = ST_FULL;
      end
    end else if (esc_q == ESC_AFTER) begin
      esc_d = (b == CH_LBRACK) ? ESC_CSI : ESC_NORMAL;
    end else if (esc_q == ESC_CSI) begin
      if (b >= FINAL_LO && b <= FINAL_HI) esc_d = ESC_NORMAL;
    end else begin
      unique case (b)
        CH_LF, CH_CR: begin
          ends = 1'b1;
          res.status = ST_DONE;
          res.echo_valid = 1'b1;
          res.echo_byte = CH_LF;
        end
        CH_EOT: begin
          ends = 1'b1;
          res.status = ST_CLOSED;
        end
        CH_BS, CH_DEL: begin
          if (fill_q != '0) begin
            fill_d = fill_q - 1'b1;
            res.erase_count = 5'd1;
            res.line_length = 5'(fill_q - 1'b1);
          end
        end
        CH_KILL: begin
          fill_d = '0;
          res.erase_count = 5'(fill_q);
          res.line_length = 5'd0;
        end
        CH_ESC: begin
          esc_d = ESC_AFTER;
        end
        default: begin
          wr_en = 1'b1;
          fill_d = fill_inc;
          res.echo_valid = 1'b1;
          res.echo_byte = b;
          res.line_length = 5'(fill_inc);
          if (5'(fill_inc) >= limit) begin
            ends = 1'b1;
            res.status = ST_FULL;
          end
        end
      endcase
    end
    if (ends) begin
      fill_d = '0;
      esc_d = ESC_NORMAL;
      res.last = (res.line_length == 5'd0);
    end
  end

  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign stat_o.line_more = ends && (res.line_length != 5'd0);
  assign stat_o.rd_last   = ({1'b0, rd_idx_q} + 6'd1) == {1'b0, end_len_q};

  always_comb begin
    rd_res             = '0;
    rd_res.status      = end_st_q;
    rd_res.line_length = end_len_q;
    rd_res.line_valid  = 1'b1;
    rd_res.line_byte   = rdata_q;
    rd_res.last        = stat_o.rd_last;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_load && wr_en) mem_q[fill_q] <= b;
    if (cmd_i.rd_issue) rdata_q <= mem_q[rd_idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture_in) in_q <= in_data_i;
    if (cmd_i.eval_load) begin
      end_len_q <= res.line_length;
      end_st_q  <= res.status;
      out_q     <= res;
    end else if (cmd_i.rd_load) begin
      out_q <= rd_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      fill_q      <= '0;
      esc_q       <= ESC_NORMAL;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_data_i;
      if (cmd_i.eval_load) begin
        fill_q   <= fill_d;
        esc_q    <= esc_d;
        rd_idx_q <= '0;
      end else if (cmd_i.rd_load) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      if (cmd_i.eval_load || cmd_i.rd_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* design/terminal_line_editor.sv */
// top level of the terminal line editor
//
//   channel   direction  handshake            payload
//   in        input      in_valid/in_ready    tle_pkg::in_t  (cmd, data_byte)
//   out       output     out_valid/out_ready  tle_pkg::out_t (result fields)
//   cfg       input      cfg_we               line_capacity, 6 bits
//
// a request is captured, then decoded and used to update the line state
// a finished line then reads out each stored byte: store read, then result load
// an output stall holds the result register and pauses the controller
// reset clears state, fill count, escape phase and capacity (32); the store is not cleared
`default_nettype none

module terminal_line_editor (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire tle_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output tle_pkg::out_t      out_data_o,
  input  wire logic          cfg_we_i,
  input  wire logic [5:0]    cfg_data_i
);
  import tle_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tle_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* design/tle_checker.sv */
// port-level checks for the terminal line editor, bound to the top level
`default_nettype none

module tle_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_o,
  input wire tle_pkg::in_t  in_data_i,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire tle_pkg::out_t out_data_o
);
  import tle_pkg::*;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input request dropped before acceptance");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while previous one in work");

  a_edit_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_EDIT |->
      out_data_o.last && !out_data_o.line_valid)
    else $error("editing result not a single last result");

  a_readout_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.line_valid |->
      !out_data_o.echo_valid && out_data_o.erase_count == 5'd0 &&
      out_data_o.line_length != 5'd0)
    else $error("readout result carries echo or erase data");

endmodule

bind terminal_line_editor tle_checker u_tle_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

/* tb/sv/line_edit_checker.sv */
`timescale 1ns / 100ps
// request and result monitor for the terminal line editor: line predictor and field compare
module line_edit_checker (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_ready_i,
  input  wire tle_pkg::in_t  in_data_i,
  input  wire logic          out_valid_i,
  input  wire logic          out_ready_i,
  input  wire tle_pkg::out_t out_data_i,
  input  wire logic          cfg_we_i,
  input  wire logic [5:0]    cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import tle_pkg::*;

  localparam int PRINT_CAP = 50;

  logic [7:0] line_copy [STORE_DEPTH];
  int         fill;
  logic [1:0] esc_phase;
  logic [5:0] capacity;
  out_t       editor_replies [$];
  int         mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  function automatic int char_limit();
    logic [5:0] c;
    c = capacity;
    if (c < CAP_MIN) begin
      c = CAP_MIN;
    end
    if (c > CAP_MAX) begin
      c = CAP_MAX;
    end
    return int'(c) - 1;
  endfunction

  task automatic edit_reply(input logic ev, input logic [7:0] eb, input int erase);
    out_t r;
    r = '0;
    r.echo_valid  = ev;
    r.echo_byte   = ev ? eb : 8'h00;
    r.erase_count = 5'(erase);
    r.status      = ST_EDIT;
    r.line_length = 5'(fill);
    r.last        = 1'b1;
    editor_replies.push_back(r);
  endtask

  task automatic close_line(input logic [2:0] st, input logic ev, input logic [7:0] eb);
    out_t r;
    int   n;
    int   i;
    n = fill;
    r = '0;
    r.echo_valid  = ev;
    r.echo_byte   = ev ? eb : 8'h00;
    r.status      = st;
    r.line_length = 5'(n);
    r.last        = (n == 0);
    editor_replies.push_back(r);
    for (i = 0; i < n; i++) begin
      r = '0;
      r.status      = st;
      r.line_length = 5'(n);
      r.line_valid  = 1'b1;
      r.line_byte   = line_copy[i];
      r.last        = (i + 1 == n);
      editor_replies.push_back(r);
    end
    fill      = 0;
    esc_phase = ESC_NORMAL;
  endtask

  task automatic apply_keystroke(input in_t req);
    int         lim;
    int         n;
    logic [7:0] b;
    lim = char_limit();
    b   = req.data_byte;
    case (req.cmd)
      CMD_FAIL: begin
        close_line(ST_FAILED, 1'b0, 8'h00);
      end
      CMD_RX, CMD_PRELOAD: begin
        if (fill >= lim) begin
          close_line(ST_FULL, 1'b0, 8'h00);
        end else if (req.cmd == CMD_PRELOAD) begin
          line_copy[fill] = b;
          fill++;
          if (fill >= lim) begin
            close_line(ST_FULL, 1'b0, 8'h00);
          end else begin
            edit_reply(1'b0, 8'h00, 0);
          end
        end else if (esc_phase == ESC_AFTER) begin
          esc_phase = (b == CH_LBRACK) ? ESC_CSI : ESC_NORMAL;
          edit_reply(1'b0, 8'h00, 0);
        end else if (esc_phase == ESC_CSI) begin
          if (b >= FINAL_LO && b <= FINAL_HI) begin
            esc_phase = ESC_NORMAL;
          end
          edit_reply(1'b0, 8'h00, 0);
        end else if (b == CH_LF || b == CH_CR) begin
          close_line(ST_DONE, 1'b1, CH_LF);
        end else if (b == CH_EOT) begin
          close_line(ST_CLOSED, 1'b0, 8'h00);
        end else if (b == CH_BS || b == CH_DEL) begin
          if (fill > 0) begin
            fill--;
            edit_reply(1'b0, 8'h00, 1);
          end else begin
            edit_reply(1'b0, 8'h00, 0);
          end
        end else if (b == CH_KILL) begin
          n    = fill;
          fill = 0;
          edit_reply(1'b0, 8'h00, n);
        end else if (b == CH_ESC) begin
          esc_phase = ESC_AFTER;
          edit_reply(1'b0, 8'h00, 0);
        end else begin
          line_copy[fill] = b;
          fill++;
          if (fill >= lim) begin
            close_line(ST_FULL, 1'b1, b);
          end else begin
            edit_reply(1'b1, b, 0);
          end
        end
      end
      default: begin
        // unused command: current length only
        edit_reply(1'b0, 8'h00, 0);
      end
    endcase
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    end
  endtask

  task automatic check_reply(input out_t got);
    out_t want;
    if (editor_replies.size() == 0) begin
      report_mismatch("result with no request waiting for it");
    end else begin
      want = editor_replies.pop_front();
      check_field("echo_valid", got.echo_valid, want.echo_valid);
      check_field("echo_byte", got.echo_byte, want.echo_byte);
      check_field("erase_count", got.erase_count, want.erase_count);
      check_field("status", got.status, want.status);
      check_field("line_length", got.line_length, want.line_length);
      check_field("line_valid", got.line_valid, want.line_valid);
      check_field("line_byte", got.line_byte, want.line_byte);
      check_field("last", got.last, want.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill      = 0;
      esc_phase = ESC_NORMAL;
      capacity  = CAP_RESET;
      editor_replies.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        capacity = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        apply_keystroke(in_data_i);
      end
      if (out_valid_i && out_ready_i) begin
        check_reply(out_data_i);
      end
      pending_o <= editor_replies.size();
    end
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// testbench top for the terminal line editor: stimulus, idling, watchdog and verdict
module tb_top;
  import tle_pkg::*;

  localparam logic [1:0] CMD_IDLE   = 2'd3;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 80;
  localparam int PHASE_ITEMS   = 60;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       req_valid = 1'b0;
  logic       req_ready;
  in_t        req_data  = '0;
  logic       rsp_valid;
  logic       rsp_ready = 1'b0;
  out_t       rsp_data;
  logic       cfg_we    = 1'b0;
  logic [5:0] cfg_data  = '0;
  int         idle_pct  = 0;
  int         stall_pct = 0;
  int         quiet     = 0;
  int         fail_count;
  int         pending;

  always #6 clk = ~clk;

  terminal_line_editor u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_ready_o  (req_ready),
    .in_data_i   (req_data),
    .out_valid_o (rsp_valid),
    .out_ready_i (rsp_ready),
    .out_data_o  (rsp_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  line_edit_checker u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (req_valid),
    .in_ready_i   (req_ready),
    .in_data_i    (req_data),
    .out_valid_i  (rsp_valid),
    .out_ready_i  (rsp_ready),
    .out_data_i   (rsp_data),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    do @(posedge clk); while (quiet < QUIET_LIMIT);
    $display("FAILURE");
    $finish;
  end

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] data);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    req_valid <= 1'b1;
    req_data  <= '{cmd: cmd, data_byte: data};
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic finish_requests();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [5:0] cap);
    finish_requests();
    cfg_we   <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_keystrokes(input int count);
    int sent;
    int sel;
    int n;
    int k;
    sent = 0;
    while (sent < count) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        send_item(CMD_RX, 8'($urandom_range(8'h7E, 8'h20)));
      end else if (sel < 62) begin
        send_item(CMD_RX, $urandom_range(1) ? CH_CR : CH_LF);
      end else if (sel < 68) begin
        send_item(CMD_RX, $urandom_range(1) ? CH_BS : CH_DEL);
      end else if (sel < 70) begin
        send_item(CMD_RX, CH_KILL);
      end else if (sel < 72) begin
        send_item(CMD_RX, CH_EOT);
      end else if (sel < 78) begin
        send_item(CMD_RX, CH_ESC);
        if ($urandom_range(4) != 0) begin
          send_item(CMD_RX, CH_LBRACK);
          n = $urandom_range(3);
          for (k = 0; k < n; k++) begin
            send_item(CMD_RX, 8'($urandom_range(8'h3F, 8'h30)));
          end
          send_item(CMD_RX, 8'($urandom_range(FINAL_HI, FINAL_LO)));
          sent += n + 2;
        end else begin
          send_item(CMD_RX, 8'($urandom_range(255)));
          sent += 1;
        end
      end else if (sel < 85) begin
        send_item(CMD_PRELOAD, 8'($urandom_range(255)));
      end else if (sel < 87) begin
        send_item(CMD_FAIL, 8'($urandom_range(255)));
      end else if (sel < 88) begin
        send_item(CMD_IDLE, 8'($urandom_range(255)));
      end else begin
        send_item(CMD_RX, 8'($urandom_range(255)));
      end
      sent++;
    end
  endtask

  initial begin
    int         p;
    logic [5:0] caps [8];
    caps    = '{6'd32, 6'd2, 6'd63, 6'd9, 6'd0, 6'd1, 6'd17, 6'd0};
    caps[7] = 6'($urandom_range(63));
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    set_capacity(CAP_RESET);

    // edits, erase on empty line, silent preload
    send_item(CMD_RX, 8'h41);
    send_item(CMD_RX, 8'hFF);
    send_item(CMD_RX, 8'h00);
    send_item(CMD_RX, CH_BS);
    send_item(CMD_RX, CH_DEL);
    send_item(CMD_RX, CH_KILL);
    send_item(CMD_RX, CH_DEL);
    send_item(CMD_PRELOAD, 8'h80);
    send_item(CMD_PRELOAD, CH_CR);
    send_item(CMD_IDLE, 8'h55);
    // escape handling
    send_item(CMD_RX, CH_ESC);
    send_item(CMD_RX, CH_CR);
    send_item(CMD_RX, CH_ESC);
    send_item(CMD_RX, CH_LBRACK);
    send_item(CMD_PRELOAD, CH_LF);
    send_item(CMD_RX, 8'h31);
    send_item(CMD_RX, FINAL_HI);
    // line endings
    send_item(CMD_RX, CH_LF);
    send_item(CMD_RX, CH_CR);
    send_item(CMD_RX, CH_EOT);
    send_item(CMD_RX, 8'h20);
    send_item(CMD_FAIL, 8'hFF);
    send_item(CMD_RX, CH_ESC);
    send_item(CMD_RX, CH_LBRACK);
    send_item(CMD_FAIL, 8'h00);
    // capacity lowered under a partial line
    send_item(CMD_RX, 8'h61);
    send_item(CMD_RX, 8'h62);
    set_capacity(6'd3);
    send_item(CMD_RX, 8'h63);

    for (p = 0; p < 8; p++) begin
      set_capacity(caps[p]);
      case (p % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 74;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 74;
        end
        default: begin
          idle_pct  = 19;
          stall_pct = 19;
        end
      endcase
      random_keystrokes(PHASE_ITEMS);
    end

    finish_requests();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
